[rtl/rfsp_pkg.sv]
// Shared constants for the random free slot picker.
// No dependencies; imported by the divider and the core.
`timescale 1ns / 1ps

package rfsp_pkg;

  // Default and limits of the slot pool
  localparam int MAX_SLOTS_DEF = 64;

  // Fixed field widths of the channels and the register
  localparam int WORD_W = 31;
  localparam int POOL_W = 7;
  localparam int IDX_OUT_W = 6;
  localparam int LEFT_W = 7;

  // Register map: pool_size is the only register
  localparam int APB_ADDR_W = 3;
  localparam logic REG_POOL_SIZE = 1'b0;
  localparam logic [POOL_W-1:0] POOL_RESET = 7'd53;

endpackage

[rtl/rfsp_divider.sv]
// Iterative restoring remainder unit: one quotient bit per cycle.
// Depends on rfsp_pkg for the dividend width.
`timescale 1ns / 1ps

module rfsp_divider import rfsp_pkg::*; #(
  parameter int CW = 7
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [WORD_W-1:0]   dividend,
  input  logic [CW-1:0]       divisor,
  output logic                done,
  output logic [CW-1:0]       remainder
);

  localparam int NW = $clog2(WORD_W);

  logic              busy;
  logic [NW-1:0]     cnt;
  logic [CW-1:0]     rem;
  logic [WORD_W-1:0] dvd;
  logic [CW-1:0]     dvs;
  logic [CW:0]       trial;
  logic [CW-1:0]     rem_next;

  // Shift in the next dividend bit and subtract where it fits
  always_comb begin
    trial = {rem, dvd[WORD_W-1]};
    if (trial >= {1'b0, dvs}) begin
      rem_next = CW'(trial - {1'b0, dvs});
    end else begin
      rem_next = trial[CW-1:0];
    end
  end

  // Step control: load on start, advance while busy, pulse done at the end
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + NW'(1);
        if (cnt == NW'(WORD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= {dvd[WORD_W-2:0], 1'b0};
    end
  end

  assign remainder = rem;

endmodule

[rtl/rfsp_cell.sv]
// One slot of the scan chain: holds the slot's used flag and passes the
// search token to the next slot each cycle. No package dependencies.
`timescale 1ns / 1ps

module rfsp_cell #(
  parameter int IDX = 0,
  parameter int IW  = 6,
  parameter int CW  = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          clear,
  input  logic [CW-1:0] pool_n,
  input  logic          in_act,
  input  logic          in_found,
  input  logic [CW-1:0] in_k,
  input  logic [IW-1:0] in_idx,
  output logic          out_act,
  output logic          out_found,
  output logic [CW-1:0] out_k,
  output logic [IW-1:0] out_idx,
  output logic          used
);

  logic take;
  logic hit;

  // A free slot inside the pool counts toward k; claim it when k is zero
  assign take = in_act && !in_found && !used && (CW'(IDX) < pool_n);
  assign hit  = take && (in_k == '0);

  // Token valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_act <= 1'b0;
    end else begin
      out_act <= in_act;
    end
  end

  // Token payload: count down past free slots, record the claimed index
  always_ff @(posedge clk) begin
    out_found <= in_found || hit;
    out_k     <= (take && !hit) ? in_k - CW'(1) : in_k;
    out_idx   <= hit ? IW'(IDX) : in_idx;
  end

  // Used flag: clear on refill, set on claim
  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (clear) begin
      used <= 1'b0;
    end else if (hit) begin
      used <= 1'b1;
    end
  end

endmodule

[rtl/random_free_slot_picker_core.sv]
// Random free slot picker: draws slots from a pool without replacement.
// Each item runs a 31-step remainder unit, then a scan through the chain of slot
// cells; an item on an empty pool skips both and goes straight to the result.
// One item at a time: the next item is taken once the result is moved to the
// output register. Synchronous reset clears all used flags,
// loads pool_size with 53 and the free count with the pool size.
`timescale 1ns / 1ps

module random_free_slot_picker_core import rfsp_pkg::*; #(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [WORD_W-1:0]     random_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  found,
  output logic [IDX_OUT_W-1:0]  slot_index,
  output logic [LEFT_W-1:0]     slots_left
);

  localparam int IW = $clog2(MAX_SLOTS);
  localparam int CW = $clog2(MAX_SLOTS + 1);
  localparam int SW = (CW > POOL_W) ? CW : POOL_W;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_SCAN, ST_DONE} state_t;

  state_t              state;
  logic [POOL_W-1:0]   pool_size;
  logic [CW-1:0]       free_count;
  logic [CW-1:0]       pool_n;
  logic                launch_act;
  logic [CW-1:0]       launch_k;
  logic                res_found;
  logic [IW-1:0]       res_idx;
  logic [CW-1:0]       res_left;
  logic                cfg_wr;
  logic                accept;
  logic                div_start;
  logic                div_done;
  logic [CW-1:0]       div_rem;

  logic                tok_act   [MAX_SLOTS+1];
  logic                tok_found [MAX_SLOTS+1];
  logic [CW-1:0]       tok_k     [MAX_SLOTS+1];
  logic [IW-1:0]       tok_idx   [MAX_SLOTS+1];
  logic [MAX_SLOTS-1:0] used_vec;

  // Saturate a pool size to the number of slots that exist
  function automatic logic [CW-1:0] eff_pool(input logic [POOL_W-1:0] v);
    logic [SW-1:0] w;
    w = SW'(v);
    if (w > SW'(MAX_SLOTS)) begin
      return CW'(MAX_SLOTS);
    end
    return CW'(w);
  endfunction

  // Configuration port decode
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_POOL_SIZE);
  assign prdata = (paddr[2] == REG_POOL_SIZE) ? 32'(pool_size) : 32'd0;
  assign pool_n = eff_pool(pool_size);

  // Input handshake and divider launch
  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign div_start = accept && (free_count != '0);

  rfsp_divider #(
    .CW (CW)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (random_word),
    .divisor   (free_count),
    .done      (div_done),
    .remainder (div_rem)
  );

  // Scan chain: the token enters at slot 0 and leaves after the last slot
  assign tok_act[0]   = launch_act;
  assign tok_found[0] = 1'b0;
  assign tok_k[0]     = launch_k;
  assign tok_idx[0]   = '0;

  for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_cell
    rfsp_cell #(
      .IDX (i),
      .IW  (IW),
      .CW  (CW)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .clear     (cfg_wr),
      .pool_n    (pool_n),
      .in_act    (tok_act[i]),
      .in_found  (tok_found[i]),
      .in_k      (tok_k[i]),
      .in_idx    (tok_idx[i]),
      .out_act   (tok_act[i+1]),
      .out_found (tok_found[i+1]),
      .out_k     (tok_k[i+1]),
      .out_idx   (tok_idx[i+1]),
      .used      (used_vec[i])
    );
  end

  // Control, pool state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      pool_size  <= POOL_RESET;
      free_count <= eff_pool(POOL_RESET);
      launch_act <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      launch_act <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_wr) begin
        pool_size  <= pwdata[POOL_W-1:0];
        free_count <= eff_pool(pwdata[POOL_W-1:0]);
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (free_count == '0) begin
              res_found <= 1'b0;
              res_idx   <= '0;
              res_left  <= '0;
              state     <= ST_DONE;
            end else begin
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (div_done) begin
            launch_act <= 1'b1;
            launch_k   <= div_rem;
            state      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (tok_act[MAX_SLOTS]) begin
            if (tok_found[MAX_SLOTS]) begin
              res_found  <= 1'b1;
              res_idx    <= tok_idx[MAX_SLOTS];
              res_left   <= free_count - CW'(1);
              free_count <= free_count - CW'(1);
            end else begin
              res_found <= 1'b0;
              res_idx   <= '0;
              res_left  <= '0;
            end
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            found      <= res_found;
            slot_index <= IDX_OUT_W'(res_idx);
            slots_left <= LEFT_W'(res_left);
            out_valid  <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Free count never exceeds the pool
  a_free_le_pool: assert property (@(posedge clk) disable iff (rst)
    free_count <= pool_n)
    else $error("free count above pool size");

  // Used flags and free count account for the whole pool between items
  a_pool_balance: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |->
      ((CW+1)'($countones(used_vec)) + (CW+1)'(free_count) == (CW+1)'(pool_n)))
    else $error("used flags and free count disagree");

  // The token leaves the chain only while a scan is running
  a_tail_in_scan: assert property (@(posedge clk) disable iff (rst)
    tok_act[MAX_SLOTS] |-> (state == ST_SCAN))
    else $error("scan token outside scan");

  // A claim takes exactly one slot from the free count
  a_claim_dec: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && tok_act[MAX_SLOTS] && tok_found[MAX_SLOTS] && !cfg_wr)
      |=> (free_count == $past(free_count) - CW'(1)))
    else $error("free count not decremented on claim");

  // A remainder is never taken against an empty pool
  a_div_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && div_done) |-> (free_count != '0))
    else $error("division against empty pool");

endmodule

[bench/tb.sv]
// Self-checking bench for random_free_slot_picker_core: a directed table, then random
// pool phases checked against an in-bench model of the draw. Depends on rfsp_pkg
// and the core RTL only.
`timescale 1ns / 1ps

module tb;
  import rfsp_pkg::*;

  localparam int SLOTS = MAX_SLOTS_DEF;
  localparam int DRAW_LAT = WORD_W + SLOTS + 3;
  localparam int TARGET_DRAWS = 1900;
  localparam int LONG_HOLD = 600;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam logic [APB_ADDR_W-1:0] POOL_ADDR = {REG_POOL_SIZE, 2'b00};
  localparam logic [APB_ADDR_W-1:0] SPARE_ADDR = {~REG_POOL_SIZE, 2'b00};

  typedef struct packed {
    logic                 found;
    logic [IDX_OUT_W-1:0] slot;
    logic [LEFT_W-1:0]    left;
  } draw_res_t;

  typedef enum logic {ROW_DRAW, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [APB_ADDR_W-1:0] addr;
    logic [31:0]           data;
    logic                  typed;
    draw_res_t             want;
  } row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [WORD_W-1:0]     random_word = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic                  found;
  logic [IDX_OUT_W-1:0]  slot_index;
  logic [LEFT_W-1:0]     slots_left;

  // Model state of the pool
  logic [SLOTS-1:0] slot_taken;
  int unsigned      free_cnt;
  int unsigned      pool_lim;
  logic [POOL_W-1:0] pool_reg;

  draw_res_t draw_q[$];
  draw_res_t want_res;
  int        fails = 0;
  int        draws_sent = 0;
  int        cycle_cnt = 0;
  bit        tx_steady = 1'b0;
  logic      rx_steady = 1'b0;
  logic [3:0] hold_ticket = '0;
  logic [3:0] hold_seen = '0;
  int        rx_wait = 0;
  int        rx_gap;

  // Directed rows: reset pool, single slot, empty pool, saturation, ignored register
  row_t dir_rows [24] = '{
    '{ROW_DRAW, POOL_ADDR,  32'h0000_0000, 1'b1, '{1'b1, 6'd0,  7'd52}},
    '{ROW_DRAW, POOL_ADDR,  32'h7FFF_FFFF, 1'b0, '0},
    '{ROW_DRAW, POOL_ADDR,  32'h0000_0001, 1'b0, '0},
    '{ROW_CFG,  POOL_ADDR,  32'd1,         1'b0, '0},
    '{ROW_DRAW, POOL_ADDR,  32'h5555_5555, 1'b1, '{1'b1, 6'd0,  7'd0}},
    '{ROW_DRAW, POOL_ADDR,  32'h2AAA_AAAA, 1'b1, '{1'b0, 6'd0,  7'd0}},
    '{ROW_CFG,  POOL_ADDR,  32'd0,         1'b0, '0},
    '{ROW_DRAW, POOL_ADDR,  32'h0000_0000, 1'b1, '{1'b0, 6'd0,  7'd0}},
    '{ROW_DRAW, POOL_ADDR,  32'h7FFF_FFFF, 1'b1, '{1'b0, 6'd0,  7'd0}},
    '{ROW_CFG,  POOL_ADDR,  32'hFFFF_FFFF, 1'b0, '0},
    '{ROW_DRAW, POOL_ADDR,  32'd63,        1'b1, '{1'b1, 6'd63, 7'd63}},
    '{ROW_DRAW, POOL_ADDR,  32'h7FFF_FFFF, 1'b0, '0},
    '{ROW_CFG,  SPARE_ADDR, 32'd5,         1'b0, '0},
    '{ROW_DRAW, POOL_ADDR,  32'h0000_0000, 1'b0, '0},
    '{ROW_CFG,  POOL_ADDR,  32'd2,         1'b0, '0},
    '{ROW_DRAW, POOL_ADDR,  32'd1,         1'b1, '{1'b1, 6'd1,  7'd1}},
    '{ROW_DRAW, POOL_ADDR,  32'd1,         1'b1, '{1'b1, 6'd0,  7'd0}},
    '{ROW_DRAW, POOL_ADDR,  32'd0,         1'b1, '{1'b0, 6'd0,  7'd0}},
    '{ROW_CFG,  POOL_ADDR,  32'd64,        1'b0, '0},
    '{ROW_DRAW, POOL_ADDR,  32'd64,        1'b1, '{1'b1, 6'd0,  7'd63}},
    '{ROW_DRAW, POOL_ADDR,  32'h7FFF_FFFF, 1'b0, '0},
    '{ROW_CFG,  POOL_ADDR,  32'd65,        1'b0, '0},
    '{ROW_DRAW, POOL_ADDR,  32'h7FFF_FFFF, 1'b0, '0},
    '{ROW_CFG,  POOL_ADDR,  32'd53,        1'b0, '0}
  };

  random_free_slot_picker_core DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .random_word(random_word),
    .out_valid(out_valid), .out_ready(out_ready),
    .found(found), .slot_index(slot_index), .slots_left(slots_left)
  );

  always #4 clk = ~clk;

  // Mostly no gap, often a short one, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 150);
  endfunction

  // Clear every flag and load the free count from the saturated pool size
  function automatic void refill_pool();
    pool_lim = (pool_reg > SLOTS) ? SLOTS : pool_reg;
    slot_taken = '0;
    free_cnt = pool_lim;
  endfunction

  // Pick the k-th free slot, k = word mod free count, scanning from slot 0
  function automatic draw_res_t draw_slot(input logic [WORD_W-1:0] w);
    draw_res_t r;
    int unsigned k;
    int unsigned seen;
    r = '0;
    r.left = free_cnt[LEFT_W-1:0];
    if (free_cnt == 0) return r;
    k = w % free_cnt;
    seen = 0;
    for (int i = 0; i < pool_lim; i++) begin
      if (!slot_taken[i]) begin
        if (seen == k) begin
          slot_taken[i] = 1'b1;
          free_cnt--;
          r.found = 1'b1;
          r.slot = i[IDX_OUT_W-1:0];
          r.left = free_cnt[LEFT_W-1:0];
          return r;
        end
        seen++;
      end
    end
    // No slot found: answer as empty and keep the state
    r.left = '0;
    return r;
  endfunction

  task automatic wait_drained();
    while (draw_q.size() != 0) @(posedge clk);
  endtask

  // Offer one item, hold it until taken, then log its expected result
  task automatic send_draw(input logic [WORD_W-1:0] w, input logic typed,
                           input draw_res_t want);
    int gap;
    draw_res_t pred;
    gap = tx_steady ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    random_word <= w;
    do @(posedge clk); while (!in_ready);
    pred = draw_slot(w);
    draw_q.push_back(typed ? want : pred);
    draws_sent++;
  endtask

  // Register write on an idle block: setup, access, then back to idle
  task automatic write_reg(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
    in_valid <= 1'b0;
    wait_drained();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == POOL_ADDR) begin
      pool_reg = data[POOL_W-1:0];
      refill_pool();
    end
    @(posedge clk);
  endtask

  // Stimulus: reset, directed table, then random pool phases
  initial begin
    int phase;
    int n_draws;
    logic [POOL_W-1:0] pv;
    logic [WORD_W-1:0] w;
    pool_reg = POOL_RESET;
    refill_pool();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG)
        write_reg(dir_rows[i].addr, dir_rows[i].data);
      else
        send_draw(dir_rows[i].data[WORD_W-1:0], dir_rows[i].typed, dir_rows[i].want);
    end

    phase = 0;
    while (draws_sent < TARGET_DRAWS) begin
      case ($urandom_range(0, 9))
        0: pv = '0;
        1: pv = 7'd1;
        2: pv = 7'd64;
        3: pv = POOL_W'($urandom_range(65, 127));
        4, 5, 6: pv = POOL_W'($urandom_range(2, 16));
        default: pv = POOL_W'($urandom_range(1, 64));
      endcase
      write_reg(POOL_ADDR, ($urandom() & 32'hFFFF_FF80) | pv);
      if ($urandom_range(0, 7) == 0) write_reg(SPARE_ADDR, $urandom());

      // Usually drain the pool and probe it empty, sometimes stop partway
      if ($urandom_range(0, 3) == 0)
        n_draws = $urandom_range(0, pool_lim);
      else
        n_draws = pool_lim + $urandom_range(0, 3);

      tx_steady = ($urandom_range(0, 4) == 0);
      rx_steady <= ($urandom_range(0, 4) == 0);
      // Hold the receiver off while items keep coming so the input stalls
      if (phase == 3) begin
        tx_steady = 1'b0;
        n_draws = n_draws + 8;
        hold_ticket <= hold_ticket + 1'b1;
      end

      for (int j = 0; j < n_draws; j++) begin
        case ($urandom_range(0, 7))
          0: w = '0;
          1: w = '1;
          2: w = WORD_W'($urandom_range(0, 200));
          default: w = WORD_W'($urandom());
        endcase
        send_draw(w, 1'b0, '0);
      end
      phase++;
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAW_LAT + 10) @(posedge clk);
    if (fails == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

  // Receiver: random stalls, a long hold on request, and result checking
  always @(posedge clk) begin
    if (hold_seen != hold_ticket) begin
      hold_seen <= hold_ticket;
      rx_wait <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      out_ready <= 1'b0;
    end else if (rx_steady) begin
      out_ready <= 1'b1;
    end else begin
      rx_gap = idle_len();
      out_ready <= (rx_gap == 0);
      if (rx_gap > 0) rx_wait <= rx_gap - 1;
    end

    if (!rst && out_valid && out_ready) begin
      if (draw_q.size() == 0) begin
        $error("result with no pending draw: found %0d slot_index %0d slots_left %0d",
               found, slot_index, slots_left);
        fails++;
      end else begin
        want_res = draw_q.pop_front();
        if (found !== want_res.found) begin
          $error("found: expected %0d, got %0d", want_res.found, found);
          fails++;
        end
        if (slot_index !== want_res.slot) begin
          $error("slot_index: expected %0d, got %0d", want_res.slot, slot_index);
          fails++;
        end
        if (slots_left !== want_res.left) begin
          $error("slots_left: expected %0d, got %0d", want_res.left, slots_left);
          fails++;
        end
      end
    end
  end

  // Watchdog on total run length
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule
